[rtl/gti_pkg.sv]
// Package for the grid trilinear interpolator: command codes, register
// indexes, sequencer states and fixed field widths. No dependencies.
package gti_pkg;

  localparam int unsigned VAL_W  = 16;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned SIZE_W = 5;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CIDX_W = 3;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_INTERP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  localparam logic [CIDX_W-1:0] REG_SIZE_X = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SIZE_Y = 3'd1;
  localparam logic [CIDX_W-1:0] REG_SIZE_Z = 3'd2;
  localparam logic [CIDX_W-1:0] REG_STEP_X = 3'd3;
  localparam logic [CIDX_W-1:0] REG_STEP_Y = 3'd4;
  localparam logic [CIDX_W-1:0] REG_STEP_Z = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FETCH,
    ST_LERP,
    ST_READ,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [IDX_W-1:0]  index_x;
    logic [IDX_W-1:0]  index_y;
    logic [IDX_W-1:0]  index_z;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
    logic signed [VAL_W-1:0] val_x;
    logic signed [VAL_W-1:0] val_y;
    logic signed [VAL_W-1:0] val_z;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] res_x;
    logic signed [VAL_W-1:0] res_y;
    logic signed [VAL_W-1:0] res_z;
    logic                    status;
  } rsp_t;

endpackage

[rtl/gti_stream_if.sv]
// Valid/ready channel interface carrying one payload type.
// Independent of gti_pkg: the payload type T is a parameter.
interface gti_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/grid_trilinear_interpolator.sv]
// Grid trilinear interpolator top level: grid memory, shared divider and lerp unit.
// Depends on gti_pkg and gti_stream_if.
//
//  channel | dir | payload      | transfer when
//  req     | in  | gti_pkg::req_t | req.valid & req.ready
//  rsp     | out | gti_pkg::rsp_t | rsp.valid & rsp.ready
//  cfg     | in  | idx, data    | cfg_we_i
//
// Write/read: accept, write or read issue, read data capture, output, plus output wait.
// Bad command: accept, then output, plus output wait. Interpolate: three restoring
// divisions of POS_W+FRAC_BITS steps each through one shared subtractor,
// then eight corner reads (one memory port, one per cycle), then seven lerps
// with the three components in lanes; an out-of-range base skips both.
// Reset is asynchronous; the grid memory is not cleared. A stalled result
// holds in the output register and the block takes no item until it goes.
module grid_trilinear_interpolator #(
  parameter int unsigned GRID_X    = 16,
  parameter int unsigned GRID_Y    = 16,
  parameter int unsigned GRID_Z    = 16,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gti_pkg::CIDX_W-1:0]  cfg_idx_i,
  input  logic [gti_pkg::CFG_W-1:0]   cfg_data_i,
  gti_stream_if.sink                  req,
  gti_stream_if.source                rsp
);
  localparam int unsigned XW    = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int unsigned YW    = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
  localparam int unsigned ZW    = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
  localparam int unsigned AW    = XW + YW + ZW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned VW    = gti_pkg::VAL_W;
  localparam int unsigned NW    = gti_pkg::POS_W + FRAC_BITS;   // dividend width
  localparam int unsigned NCW   = $clog2(NW + 1);
  localparam int unsigned IW    = gti_pkg::POS_W;               // integer part of u
  localparam int unsigned GW    = 9;                            // size compare width

  // configuration registers
  logic [gti_pkg::SIZE_W-1:0] size_q [3];
  logic [gti_pkg::CFG_W-1:0]  step_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        size_q[i] <= gti_pkg::SIZE_W'(16);
        step_q[i] <= gti_pkg::CFG_W'(256);
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gti_pkg::REG_SIZE_X: size_q[0] <= cfg_data_i[gti_pkg::SIZE_W-1:0];
        gti_pkg::REG_SIZE_Y: size_q[1] <= cfg_data_i[gti_pkg::SIZE_W-1:0];
        gti_pkg::REG_SIZE_Z: size_q[2] <= cfg_data_i[gti_pkg::SIZE_W-1:0];
        gti_pkg::REG_STEP_X: step_q[0] <= cfg_data_i;
        gti_pkg::REG_STEP_Y: step_q[1] <= cfg_data_i;
        gti_pkg::REG_STEP_Z: step_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective sizes, min(reg, grid)
  logic [GW-1:0] eff [3];
  always_comb begin
    eff[0] = (GW'(size_q[0]) < GW'(GRID_X)) ? GW'(size_q[0]) : GW'(GRID_X);
    eff[1] = (GW'(size_q[1]) < GW'(GRID_Y)) ? GW'(size_q[1]) : GW'(GRID_Y);
    eff[2] = (GW'(size_q[2]) < GW'(GRID_Z)) ? GW'(size_q[2]) : GW'(GRID_Z);
  end

  // state
  gti_pkg::state_e state_q, state_d;
  gti_pkg::req_t   req_q;
  logic [1:0]      axis_q, axis_d;
  logic [NCW-1:0]  bit_q, bit_d;
  logic [NW-1:0]   quo_q, quo_d;
  logic [gti_pkg::CFG_W:0] rem_q, rem_d;
  logic [XW-1:0]   bx_q;
  logic [YW-1:0]   by_q;
  logic [ZW-1:0]   bz_q;
  logic [FRAC_BITS-1:0] f_q [3];
  logic            bad_q, bad_d;
  logic [3:0]      cnt_q, cnt_d;        // corner fetch count / lerp step
  logic            rd_v_q;
  logic [2:0]      rd_c_q;
  logic signed [VW-1:0] crn_q [8][3];
  logic signed [VW-1:0] res_q [3];
  logic            stat_q;
  logic            out_v_q;

  // memory
  logic [3*VW-1:0] mem [DEPTH];
  logic [3*VW-1:0] rdata_q;
  logic [AW-1:0]   raddr;
  logic            re, we;

  // shared restoring divider step
  logic [NW-1:0]   dividend;
  logic [gti_pkg::CFG_W-1:0] dsr;
  logic [gti_pkg::CFG_W:0]   trial;
  logic [gti_pkg::CFG_W+1:0] diff;
  always_comb begin
    case (axis_q)
      2'd0:    begin dividend = NW'(req_q.pos_x) << FRAC_BITS; dsr = step_q[0]; end
      2'd1:    begin dividend = NW'(req_q.pos_y) << FRAC_BITS; dsr = step_q[1]; end
      default: begin dividend = NW'(req_q.pos_z) << FRAC_BITS; dsr = step_q[2]; end
    endcase
    if (dsr == '0) dsr = gti_pkg::CFG_W'(1);
    trial = {rem_q[gti_pkg::CFG_W-1:0], dividend[NCW'(NW-1) - bit_q]};
    diff  = {1'b0, trial} - {2'b0, dsr};
  end

  // corner address: corner c bits = {a(x), b(y), z}
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [ZW-1:0] cz;
  always_comb begin
    if (state_q == gti_pkg::ST_FETCH) begin
      cx = bx_q + XW'(cnt_q[2]);
      cy = by_q + YW'(cnt_q[1]);
      cz = bz_q + ZW'(cnt_q[0]);
    end else begin
      cx = XW'(req_q.index_x);
      cy = YW'(req_q.index_y);
      cz = ZW'(req_q.index_z);
    end
    raddr = {cx, cy, cz};
  end

  // shared lerp unit: 7 steps per component, all three components in lanes
  logic [FRAC_BITS-1:0] lf;
  logic [2:0] la, lb;
  always_comb begin
    la = 3'd0; lb = 3'd1; lf = f_q[2];
    case (cnt_q)
      4'd0: begin la = 3'd0; lb = 3'd1; lf = f_q[2]; end
      4'd1: begin la = 3'd2; lb = 3'd3; lf = f_q[2]; end
      4'd2: begin la = 3'd4; lb = 3'd5; lf = f_q[2]; end
      4'd3: begin la = 3'd6; lb = 3'd7; lf = f_q[2]; end
      4'd4: begin la = 3'd0; lb = 3'd2; lf = f_q[1]; end
      4'd5: begin la = 3'd4; lb = 3'd6; lf = f_q[1]; end
      4'd6: begin la = 3'd0; lb = 3'd4; lf = f_q[0]; end
      default: ;
    endcase
  end

  logic signed [VW-1:0] lres [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [VW:0]             d;
      logic signed [VW+FRAC_BITS+1:0] p;
      d = {crn_q[lb][k][VW-1], crn_q[lb][k]} - {crn_q[la][k][VW-1], crn_q[la][k]};
      p = (VW+FRAC_BITS+2)'(d) * $signed({2'b0, lf});
      lres[k] = crn_q[la][k] + VW'(p >>> FRAC_BITS);
    end
  end

  assign req.ready = (state_q == gti_pkg::ST_IDLE);
  assign we  = (state_q == gti_pkg::ST_READ) && (req_q.cmd == gti_pkg::CMD_WRITE) &&
               !idx_bad && (cnt_q == 4'd0);
  assign re  = (state_q == gti_pkg::ST_FETCH && cnt_q < 4'd8) ||
               (state_q == gti_pkg::ST_READ);

  // index range check for read/write
  logic idx_bad;
  assign idx_bad = !(GW'(req_q.index_x) < eff[0] && GW'(req_q.index_y) < eff[1] &&
                     GW'(req_q.index_z) < eff[2]);

  // next state
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    bit_d   = bit_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    bad_d   = bad_q;
    cnt_d   = cnt_q;
    case (state_q)
      gti_pkg::ST_IDLE: begin
        if (req.valid) begin
          axis_d = 2'd0; bit_d = '0; quo_d = '0; rem_d = '0; bad_d = 1'b0;
          cnt_d  = '0;
          case (gti_pkg::cmd_e'(req.data.cmd))
            gti_pkg::CMD_INTERP: state_d = gti_pkg::ST_DIV;
            gti_pkg::CMD_NONE:   begin bad_d = 1'b1; state_d = gti_pkg::ST_OUT; end
            default:             state_d = gti_pkg::ST_READ;
          endcase
        end
      end
      gti_pkg::ST_DIV: begin
        if (!diff[gti_pkg::CFG_W+1]) begin
          rem_d = diff[gti_pkg::CFG_W:0];
          quo_d = {quo_q[NW-2:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[NW-2:0], 1'b0};
        end
        if (bit_q == NCW'(NW-1)) begin
          bit_d = '0; rem_d = '0;
          if (axis_q == 2'd2) begin
            state_d = gti_pkg::ST_FETCH;
          end
          axis_d = axis_q + 2'd1;
        end else begin
          bit_d = bit_q + NCW'(1);
        end
      end
      gti_pkg::ST_FETCH: begin
        if (bad_q) begin
          state_d = gti_pkg::ST_OUT;
        end else if (cnt_q == 4'd8) begin
          cnt_d = '0; state_d = gti_pkg::ST_LERP;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      gti_pkg::ST_LERP: begin
        if (cnt_q == 4'd6) state_d = gti_pkg::ST_OUT;
        cnt_d = cnt_q + 4'd1;
      end
      gti_pkg::ST_READ: begin
        // first cycle writes or issues the read, second takes the read data
        bad_d = idx_bad;
        if (cnt_q == 4'd0) cnt_d = 4'd1;
        else state_d = gti_pkg::ST_OUT;
      end
      gti_pkg::ST_OUT: begin
        if (out_v_q && rsp.ready) state_d = gti_pkg::ST_IDLE;
      end
      default: state_d = gti_pkg::ST_IDLE;
    endcase
  end

  // quotient finished for an axis: base index and fraction
  logic [NW-1:0] qfin;
  logic [IW-1:0] ibase;
  logic          ax_bad;
  always_comb begin
    qfin   = quo_d;
    ibase  = qfin[NW-1:FRAC_BITS];
    ax_bad = ({1'b0, ibase} + (IW+1)'(1)) >=
             (IW+1)'(eff[(axis_q == 2'd3) ? 2'd2 : axis_q]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gti_pkg::ST_IDLE;
      axis_q  <= '0;
      bit_q   <= '0;
      bad_q   <= 1'b0;
      cnt_q   <= '0;
      rd_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      bit_q   <= bit_d;
      cnt_q   <= cnt_d;
      rd_v_q  <= re && (state_q == gti_pkg::ST_FETCH);
      bad_q   <= bad_d | (state_q == gti_pkg::ST_DIV && bit_q == NCW'(NW-1) && ax_bad);
      if (out_v_q && rsp.ready) out_v_q <= 1'b0;
      else if (state_q != gti_pkg::ST_OUT && state_d == gti_pkg::ST_OUT) out_v_q <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    rd_c_q <= cnt_q[2:0];
    if (req.valid && req.ready) req_q <= req.data;
    if (state_q == gti_pkg::ST_DIV && bit_q == NCW'(NW-1)) begin
      f_q[axis_q] <= qfin[FRAC_BITS-1:0];
      case (axis_q)
        2'd0:    bx_q <= XW'(ibase);
        2'd1:    by_q <= YW'(ibase);
        default: bz_q <= ZW'(ibase);
      endcase
    end
    if (rd_v_q) begin
      crn_q[rd_c_q][0] <= rdata_q[3*VW-1:2*VW];
      crn_q[rd_c_q][1] <= rdata_q[2*VW-1:VW];
      crn_q[rd_c_q][2] <= rdata_q[VW-1:0];
    end
    if (state_q == gti_pkg::ST_LERP) begin
      for (int k = 0; k < 3; k++) crn_q[la][k] <= lres[k];
    end
    // result capture
    if (state_q == gti_pkg::ST_LERP && cnt_q == 4'd6) begin
      for (int k = 0; k < 3; k++) res_q[k] <= lres[k];
      stat_q <= 1'b0;
    end else if (state_q == gti_pkg::ST_FETCH && bad_q) begin
      for (int k = 0; k < 3; k++) res_q[k] <= '0;
      stat_q <= 1'b1;
    end else if (state_q == gti_pkg::ST_IDLE && req.valid &&
                 req.data.cmd == gti_pkg::CMD_NONE) begin
      for (int k = 0; k < 3; k++) res_q[k] <= '0;
      stat_q <= 1'b1;
    end else if (state_q == gti_pkg::ST_READ && cnt_q == 4'd1) begin
      if (req_q.cmd == gti_pkg::CMD_READ && !bad_q) begin
        res_q[0] <= rdata_q[3*VW-1:2*VW];
        res_q[1] <= rdata_q[2*VW-1:VW];
        res_q[2] <= rdata_q[VW-1:0];
      end else begin
        for (int k = 0; k < 3; k++) res_q[k] <= '0;
      end
      stat_q <= bad_q;
    end
  end

  // grid memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) mem[raddr] <= {req_q.val_x, req_q.val_y, req_q.val_z};
    if (re) rdata_q <= mem[raddr];
  end

  assign rsp.valid       = out_v_q;
  assign rsp.data.res_x  = res_q[0];
  assign rsp.data.res_y  = res_q[1];
  assign rsp.data.res_z  = res_q[2];
  assign rsp.data.status = stat_q;
endmodule

[rtl/gti_checker.sv]
// Port-level checker for the grid trilinear interpolator, bound to the top.
// Uses neither gti_pkg nor gti_stream_if; it sees the top through plain ports.
module gti_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_status,
  input logic [47:0] rsp_res
);
  // result held while stalled
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_res))
    else $error("result changed while stalled");

  // no new item taken while a result waits
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready)
    else $error("input ready while result pending");

  // bad status carries zero data
  a_zero_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_status |-> rsp_res == '0)
    else $error("nonzero result with error status");

  // after a request transfer, not ready next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("ready straight after transfer");
endmodule

bind grid_trilinear_interpolator gti_checker u_gti_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.data.status),
  .rsp_res    ({rsp.data.res_x, rsp.data.res_y, rsp.data.res_z})
);
